// File: rtl/core/stl_pkg.sv
// Shared types, character codes and keyword helpers for the script token lexer.
package stl_pkg;

	localparam int NUM_SLOTS = 4;

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_COMMENT = 3'd1,
		MODE_IDENT   = 3'd2,
		MODE_NUMBER  = 3'd3,
		MODE_STRING  = 3'd4,
		MODE_ESCAPE  = 3'd5,
		MODE_OPER    = 3'd6
	} mode_t;

	typedef enum logic [3:0] {
		KIND_IDENT   = 4'd0,
		KIND_BOOL    = 4'd1,
		KIND_NUMBER  = 4'd2,
		KIND_STRING  = 4'd3,
		KIND_OPER    = 4'd4,
		KIND_LPAREN  = 4'd5,
		KIND_RPAREN  = 4'd6,
		KIND_COMMA   = 4'd7,
		KIND_END     = 4'd8,
		KIND_UNKNOWN = 4'd9
	} kind_t;

	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_LOW_N  = 8'h6E;
	localparam logic [7:0] CH_LOW_R  = 8'h72;
	localparam logic [7:0] CH_LOW_T  = 8'h74;

	localparam logic [4:0] KW_START = 5'b11000;

	// Keyword spellings, one byte per entry
	localparam logic [7:0] WORD_TRUE  [4] = '{8'h74, 8'h72, 8'h75, 8'h65};
	localparam logic [7:0] WORD_FALSE [5] = '{8'h66, 8'h61, 8'h6C, 8'h73, 8'h65};

	// Control part of the lexer state
	typedef struct packed {
		mode_t      mode;
		logic       quote_single;
		logic       seen_dot;
		logic [4:0] keyword_progress; // [4] true live, [3] false live, [2:0] count
	} tok_ctl_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  value_byte;
		logic        byte_valid;
		logic        token_done;
		logic [15:0] start_line;
		logic [15:0] start_column;
	} result_t;

	typedef struct packed {
		result_t [NUM_SLOTS-1:0] slot;
		logic [2:0]              count;
	} bundle_t;

	function automatic logic [4:0] feed_keyword(input logic [4:0] kp, input logic [7:0] c);
		logic [2:0] n;
		logic       t;
		logic       f;
		n = kp[2:0];
		t = kp[4];
		f = kp[3];
		if (!(n < 3'd4 && c == WORD_TRUE[n[1:0]])) t = 1'b0;
		if (!(n < 3'd5 && c == WORD_FALSE[(n < 3'd5) ? n : 3'd0])) f = 1'b0;
		if (n < 3'd7) n = n + 3'd1;
		return {t, f, n};
	endfunction

	function automatic kind_t close_kind(input mode_t m, input logic [4:0] kp);
		kind_t k;
		case (m)
			MODE_IDENT: begin
				if ((kp[4] && kp[2:0] == 3'd4) || (kp[3] && kp[2:0] == 3'd5)) k = KIND_BOOL;
				else k = KIND_IDENT;
			end
			MODE_NUMBER: k = KIND_NUMBER;
			MODE_STRING, MODE_ESCAPE: k = KIND_STRING;
			default: k = KIND_OPER;
		endcase
		return k;
	endfunction

	function automatic logic is_token_mode(input mode_t m);
		return m inside {MODE_IDENT, MODE_NUMBER, MODE_STRING, MODE_ESCAPE, MODE_OPER};
	endfunction

endpackage

// File: rtl/core/stl_if.sv
// Handshake channels for source bytes and lexer result items.
interface stl_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       end_of_source;

	modport source (output valid, output ch, output end_of_source, input ready);
	modport sink   (input valid, input ch, input end_of_source, output ready);
endinterface

interface stl_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  token_kind;
	logic [7:0]  value_byte;
	logic        byte_valid;
	logic        token_done;
	logic [15:0] start_line;
	logic [15:0] start_column;
	logic        last_result;

	modport source (output valid, output token_kind, output value_byte, output byte_valid,
		output token_done, output start_line, output start_column, output last_result,
		input ready);
	modport sink   (input valid, input token_kind, input value_byte, input byte_valid,
		input token_done, input start_line, input start_column, input last_result,
		output ready);
endinterface

// File: rtl/core/stl_lex_step.sv
// Per-byte lexer step: next state and the packed list of result items.
module stl_lex_step #(
	parameter int LINE_BITS   = 16,
	parameter int COLUMN_BITS = 16
) (
	input  logic [7:0]             ch,
	input  logic                   last,
	input  stl_pkg::tok_ctl_t      ctl,
	input  logic [LINE_BITS-1:0]   line,
	input  logic [COLUMN_BITS-1:0] col,
	input  logic [LINE_BITS-1:0]   tline,
	input  logic [COLUMN_BITS-1:0] tcol,
	output stl_pkg::tok_ctl_t      ctl_n,
	output logic [LINE_BITS-1:0]   line_n,
	output logic [COLUMN_BITS-1:0] col_n,
	output logic [LINE_BITS-1:0]   tline_n,
	output logic [COLUMN_BITS-1:0] tcol_n,
	output stl_pkg::bundle_t       bundle
);
	import stl_pkg::*;

	function automatic logic [15:0] clip16(input logic [31:0] v);
		return (|v[31:16]) ? 16'hFFFF : v[15:0];
	endfunction

	logic alpha, digit, ident_cont, quote_hit;
	logic [15:0] line16, col16, tline16, tcol16;
	logic [COLUMN_BITS-1:0] col_inc;
	logic [LINE_BITS-1:0]   line_inc;

	assign alpha      = (ch >= 8'h61 && ch <= 8'h7A) || (ch >= 8'h41 && ch <= 8'h5A);
	assign digit      = (ch >= 8'h30 && ch <= 8'h39);
	assign ident_cont = alpha || digit || ch == CH_UNDER;
	assign quote_hit  = ctl.quote_single ? (ch == CH_SQUOTE) : (ch == CH_DQUOTE);
	assign line16     = clip16(32'(line));
	assign col16      = clip16(32'(col));
	assign tline16    = clip16(32'(tline));
	assign tcol16     = clip16(32'(tcol));
	assign col_inc    = (col == '1) ? col : col + 1'b1;
	assign line_inc   = (line == '1) ? line : line + 1'b1;

	always_comb begin
		result_t          cand [NUM_SLOTS];
		logic [NUM_SLOTS-1:0] pres;
		logic             do_idle;
		logic             do_close;
		logic [7:0]       esc;
		kind_t            k;
		logic [2:0]       cnt;

		ctl_n    = ctl;
		line_n   = line;
		col_n    = col;
		tline_n  = tline;
		tcol_n   = tcol;
		pres     = '0;
		do_idle  = 1'b0;
		do_close = 1'b0;
		esc      = ch;
		k        = KIND_UNKNOWN;
		for (int i = 0; i < NUM_SLOTS; i++) cand[i] = '0;

		// Continue the open token
		case (ctl.mode)
			MODE_COMMENT: begin
				if (ch == CH_LF) do_idle = 1'b1;
				else col_n = col_inc;
			end
			MODE_IDENT: begin
				if (ident_cont) begin
					ctl_n.keyword_progress = feed_keyword(ctl.keyword_progress, ch);
					cand[1] = '{KIND_IDENT, ch, 1'b1, 1'b0, tline16, tcol16};
					pres[1] = 1'b1;
					col_n   = col_inc;
				end else begin
					do_close = 1'b1;
					do_idle  = 1'b1;
				end
			end
			MODE_NUMBER: begin
				if (digit || (ch == CH_DOT && !ctl.seen_dot)) begin
					if (ch == CH_DOT) ctl_n.seen_dot = 1'b1;
					cand[1] = '{KIND_NUMBER, ch, 1'b1, 1'b0, tline16, tcol16};
					pres[1] = 1'b1;
					col_n   = col_inc;
				end else begin
					do_close = 1'b1;
					do_idle  = 1'b1;
				end
			end
			MODE_STRING: begin
				if (quote_hit) begin
					cand[1]    = '{KIND_STRING, 8'h00, 1'b0, 1'b1, tline16, tcol16};
					pres[1]    = 1'b1;
					ctl_n.mode = MODE_IDLE;
				end else if (ch == CH_BSLASH) begin
					ctl_n.mode = MODE_ESCAPE;
				end else begin
					cand[1] = '{KIND_STRING, ch, 1'b1, 1'b0, tline16, tcol16};
					pres[1] = 1'b1;
				end
				col_n = col_inc;
			end
			MODE_ESCAPE: begin
				if (ch == CH_LOW_N) esc = CH_LF;
				else if (ch == CH_LOW_T) esc = CH_TAB;
				else if (ch == CH_LOW_R) esc = CH_CR;
				cand[1]    = '{KIND_STRING, esc, 1'b1, 1'b0, tline16, tcol16};
				pres[1]    = 1'b1;
				ctl_n.mode = MODE_STRING;
				col_n      = col_inc;
			end
			MODE_OPER: begin
				if (ch == CH_EQ) begin
					cand[1]    = '{KIND_OPER, ch, 1'b1, 1'b1, tline16, tcol16};
					pres[1]    = 1'b1;
					ctl_n.mode = MODE_IDLE;
					col_n      = col_inc;
				end else begin
					do_close = 1'b1;
					do_idle  = 1'b1;
				end
			end
			default: do_idle = 1'b1;
		endcase

		if (do_close) begin
			cand[0] = '{close_kind(ctl.mode, ctl.keyword_progress), 8'h00, 1'b0, 1'b1,
				tline16, tcol16};
			pres[0] = 1'b1;
		end

		// Lex the byte from between tokens
		if (do_idle) begin
			ctl_n.mode = MODE_IDLE;
			if (ch == CH_SPACE || ch == CH_TAB || ch == CH_CR) begin
				col_n = col_inc;
			end else if (ch == CH_LF) begin
				line_n = line_inc;
				col_n  = COLUMN_BITS'(1);
			end else if (ch == CH_HASH) begin
				ctl_n.mode = MODE_COMMENT;
				col_n      = col_inc;
			end else if (alpha || ch == CH_UNDER) begin
				ctl_n.mode             = MODE_IDENT;
				ctl_n.keyword_progress = feed_keyword(KW_START, ch);
				tline_n = line;
				tcol_n  = col;
				cand[1] = '{KIND_IDENT, ch, 1'b1, 1'b0, line16, col16};
				pres[1] = 1'b1;
				col_n   = col_inc;
			end else if (digit || ch == CH_MINUS) begin
				ctl_n.mode     = MODE_NUMBER;
				ctl_n.seen_dot = 1'b0;
				tline_n = line;
				tcol_n  = col;
				cand[1] = '{KIND_NUMBER, ch, 1'b1, 1'b0, line16, col16};
				pres[1] = 1'b1;
				col_n   = col_inc;
			end else if (ch == CH_DQUOTE || ch == CH_SQUOTE) begin
				ctl_n.mode         = MODE_STRING;
				ctl_n.quote_single = (ch == CH_SQUOTE);
				tline_n = line;
				tcol_n  = col;
				col_n   = col_inc;
			end else if (ch == CH_LT || ch == CH_GT || ch == CH_EQ || ch == CH_BANG) begin
				ctl_n.mode = MODE_OPER;
				tline_n = line;
				tcol_n  = col;
				cand[1] = '{KIND_OPER, ch, 1'b1, 1'b0, line16, col16};
				pres[1] = 1'b1;
				col_n   = col_inc;
			end else begin
				if (ch == CH_LPAREN) k = KIND_LPAREN;
				else if (ch == CH_RPAREN) k = KIND_RPAREN;
				else if (ch == CH_COMMA) k = KIND_COMMA;
				cand[1] = '{k, ch, 1'b1, 1'b1, line16, col16};
				pres[1] = 1'b1;
				col_n   = col_inc;
			end
		end

		// End of source: close what is open, send END, return to reset state
		if (last) begin
			if (is_token_mode(ctl_n.mode)) begin
				cand[2] = '{close_kind(ctl_n.mode, ctl_n.keyword_progress), 8'h00, 1'b0, 1'b1,
					clip16(32'(tline_n)), clip16(32'(tcol_n))};
				pres[2] = 1'b1;
			end
			cand[3] = '{KIND_END, 8'h00, 1'b0, 1'b1, clip16(32'(line_n)), clip16(32'(col_n))};
			pres[3] = 1'b1;
			ctl_n   = '{MODE_IDLE, 1'b0, 1'b0, 5'd0};
			line_n  = LINE_BITS'(1);
			col_n   = COLUMN_BITS'(1);
			tline_n = LINE_BITS'(1);
			tcol_n  = COLUMN_BITS'(1);
		end

		// Pack present results in order
		bundle = '0;
		cnt    = 3'd0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (pres[i]) begin
				bundle.slot[cnt[1:0]] = cand[i];
				cnt = cnt + 3'd1;
			end
		end
		bundle.count = cnt;
	end

endmodule

// File: rtl/core/stl_result_buf.sv
// Result buffer: holds one byte's items and hands out one per cycle while ready.
module stl_result_buf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  stl_pkg::bundle_t bundle,
	output logic             free,
	stl_out_if.source        token
);
	import stl_pkg::*;

	result_t [NUM_SLOTS-1:0] slot_s2;
	logic [2:0]              count_q;
	logic [1:0]              idx_q;
	logic                    at_last;
	logic                    take;
	result_t                 cur;

	assign cur     = slot_s2[idx_q];
	assign at_last = ({1'b0, idx_q} == count_q - 3'd1);
	assign take    = token.valid && token.ready;
	assign free    = (count_q == 3'd0) || (take && at_last);

	assign token.valid        = (count_q != 3'd0);
	assign token.token_kind   = cur.kind;
	assign token.value_byte   = cur.value_byte;
	assign token.byte_valid   = cur.byte_valid;
	assign token.token_done   = cur.token_done;
	assign token.start_line   = cur.start_line;
	assign token.start_column = cur.start_column;
	assign token.last_result  = at_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 3'd0;
			idx_q   <= 2'd0;
		end else if (load) begin
			count_q <= bundle.count;
			idx_q   <= 2'd0;
		end else if (take) begin
			if (at_last) begin
				count_q <= 3'd0;
				idx_q   <= 2'd0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) slot_s2 <= bundle.slot;
	end

endmodule

// File: rtl/core/script_token_lexer.sv
// Streaming script lexer: source bytes in, token text and token-done items out.
// A byte is registered in the input stage and its result items in the result buffer.
// Throughput: one byte per cycle while bytes yield at most one item and ready is high;
//   a byte with more items (up to four) holds the result buffer until all are taken.
// Reset (arst_n low) empties both stages and sets line, column and token start to 1.
module script_token_lexer #(
	parameter int LINE_BITS   = 16,
	parameter int COLUMN_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	stl_in_if.sink    text,
	stl_out_if.source token
);
	import stl_pkg::*;

	// Input stage
	logic       valid_s1;
	logic [7:0] ch_s1;
	logic       eos_s1;

	// Lexer state
	tok_ctl_t               ctl_q;
	logic [LINE_BITS-1:0]   line_q;
	logic [COLUMN_BITS-1:0] col_q;
	logic [LINE_BITS-1:0]   tline_q;
	logic [COLUMN_BITS-1:0] tcol_q;

	// Next state and results of the byte in the input stage
	tok_ctl_t               ctl_n;
	logic [LINE_BITS-1:0]   line_n;
	logic [COLUMN_BITS-1:0] col_n;
	logic [LINE_BITS-1:0]   tline_n;
	logic [COLUMN_BITS-1:0] tcol_n;
	bundle_t                bundle;

	logic free;
	logic advance;

	// Advance the staged byte once the result buffer is empty or draining its last item;
	// a byte that yields no item still waits its turn so the order stays intact.
	assign advance    = valid_s1 && free;
	assign text.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.ready && text.valid) begin
			ch_s1  <= text.ch;
			eos_s1 <= text.end_of_source;
		end
	end

	// Commit the state only when the byte moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q   <= '{MODE_IDLE, 1'b0, 1'b0, 5'd0};
			line_q  <= LINE_BITS'(1);
			col_q   <= COLUMN_BITS'(1);
			tline_q <= LINE_BITS'(1);
			tcol_q  <= COLUMN_BITS'(1);
		end else if (advance) begin
			ctl_q   <= ctl_n;
			line_q  <= line_n;
			col_q   <= col_n;
			tline_q <= tline_n;
			tcol_q  <= tcol_n;
		end
	end

	stl_lex_step #(
		.LINE_BITS   (LINE_BITS),
		.COLUMN_BITS (COLUMN_BITS)
	) u_step (
		.ch      (ch_s1),
		.last    (eos_s1),
		.ctl     (ctl_q),
		.line    (line_q),
		.col     (col_q),
		.tline   (tline_q),
		.tcol    (tcol_q),
		.ctl_n   (ctl_n),
		.line_n  (line_n),
		.col_n   (col_n),
		.tline_n (tline_n),
		.tcol_n  (tcol_n),
		.bundle  (bundle)
	);

	// Load only bytes that yield items; whitespace and comments pass through silently
	stl_result_buf u_buf (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance && (bundle.count != 3'd0)),
		.bundle (bundle),
		.free   (free),
		.token  (token)
	);

endmodule
